FILE: hw/rtl/bmsrfd_pkg.sv
`timescale 1ns / 1ps

package bmsrfd_pkg;

  localparam int FRAME_BYTES    = 13;
  localparam int MAX_CELLS      = 48;
  localparam int MAX_SENSORS    = 16;
  localparam int CURRENT_OFFSET = 30000;
  localparam int TEMP_OFFSET    = 40;
  localparam int CELLS_PER_FRAME = 3;
  localparam int TEMPS_PER_FRAME = 7;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CHECKSUM  = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  localparam logic [7:0] CMD_PACK      = 8'h90;
  localparam logic [7:0] CMD_EXTREMES  = 8'h91;
  localparam logic [7:0] CMD_TEMP      = 8'h92;
  localparam logic [7:0] CMD_FET       = 8'h93;
  localparam logic [7:0] CMD_STATUS    = 8'h94;
  localparam logic [7:0] CMD_CELL_MV   = 8'h95;
  localparam logic [7:0] CMD_CELL_TEMP = 8'h96;
  localparam logic [7:0] CMD_BALANCE   = 8'h97;

  localparam logic [4:0] K_PACK_V      = 5'd0;
  localparam logic [4:0] K_PACK_I      = 5'd1;
  localparam logic [4:0] K_SOC         = 5'd2;
  localparam logic [4:0] K_MAX_MV      = 5'd3;
  localparam logic [4:0] K_MAX_CELL    = 5'd4;
  localparam logic [4:0] K_MIN_MV      = 5'd5;
  localparam logic [4:0] K_MIN_CELL    = 5'd6;
  localparam logic [4:0] K_DELTA_MV    = 5'd7;
  localparam logic [4:0] K_AVG_TEMP    = 5'd8;
  localparam logic [4:0] K_CHG_STATE   = 5'd9;
  localparam logic [4:0] K_CHG_FET     = 5'd10;
  localparam logic [4:0] K_DSG_FET     = 5'd11;
  localparam logic [4:0] K_HEARTBEAT   = 5'd12;
  localparam logic [4:0] K_RESIDUAL    = 5'd13;
  localparam logic [4:0] K_CELL_COUNT  = 5'd14;
  localparam logic [4:0] K_SENS_COUNT  = 5'd15;
  localparam logic [4:0] K_CHARGER     = 5'd16;
  localparam logic [4:0] K_LOAD        = 5'd17;
  localparam logic [4:0] K_DIO         = 5'd18;
  localparam logic [4:0] K_CYCLES      = 5'd19;
  localparam logic [4:0] K_CELL_MV     = 5'd20;
  localparam logic [4:0] K_SENS_TEMP   = 5'd21;
  localparam logic [4:0] K_BAL_MASK    = 5'd22;
  localparam logic [4:0] K_BAL_ACTIVE  = 5'd23;

  // frame bytes 4..11 packed, byte 4 in the low octet
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  cmd;
    logic [63:0] data;
    logic [5:0]  elem;
    logic [7:0]  limit;
  } burst_t;

  // element count reached after the k-th element of a frame
  function automatic logic hit_limit(logic [5:0] elem, logic [2:0] k, logic [7:0] limit);
    logic [5:0] nx;
    nx = elem + {3'b000, k} + 6'd1;
    return {2'b00, nx} >= limit;
  endfunction

endpackage

FILE: hw/rtl/bmsrfd_in_if.sv
`timescale 1ns / 1ps

interface bmsrfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output command, output rx_byte, input ready);
  modport sink (input valid, input action, input command, input rx_byte, output ready);
endinterface

FILE: hw/rtl/bmsrfd_out_if.sv
`timescale 1ns / 1ps

interface bmsrfd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         cmd_echo;
  logic [4:0]         item_kind;
  logic [5:0]         item_index;
  logic signed [48:0] item_value;
  logic               last;

  modport source (output valid, output status, output cmd_echo, output item_kind,
                  output item_index, output item_value, output last, input ready);
  modport sink (input valid, input status, input cmd_echo, input item_kind,
                input item_index, input item_value, input last, output ready);
endinterface

FILE: hw/rtl/bms_response_frame_decoder.sv
`timescale 1ns / 1ps

// channel   dir  fields
// items     in   action, command, rx_byte
// results   out  status, cmd_echo, item_kind, item_index, item_value, last
//
// one input transfer per cycle unless an item is held waiting; each item passes through the input register
// a frame end, timeout or bad count queues a burst of one to seven results, one per cycle while results are ready
// an item that makes results waits in the input register while a burst is still draining
// synchronous active-high reset clears control state; the frame store is not cleared
// the results side may stall freely; items keep flowing until the input register fills
module bms_response_frame_decoder (
  input  logic          clk,
  input  logic          rst,
  bmsrfd_in_if.sink     items,
  bmsrfd_out_if.source  results
);
  import bmsrfd_pkg::*;

  logic   burst_load;
  logic   emit_free;
  burst_t burst;

  bmsrfd_rx u_rx (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .emit_free  (emit_free),
    .burst_load (burst_load),
    .burst      (burst)
  );

  bmsrfd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .burst_load (burst_load),
    .burst      (burst),
    .emit_free  (emit_free),
    .results    (results)
  );

endmodule

FILE: hw/rtl/bmsrfd_rx.sv
`timescale 1ns / 1ps

module bmsrfd_rx (
  input  logic                clk,
  input  logic                rst,
  bmsrfd_in_if.sink           items,
  input  logic                emit_free,
  output logic                burst_load,
  output bmsrfd_pkg::burst_t  burst
);
  import bmsrfd_pkg::*;

  // input register
  logic       pend_valid;
  logic [1:0] pend_action;
  logic [7:0] pend_command;
  logic [7:0] pend_byte;

  logic [7:0] frame_store [0:FRAME_BYTES-1];
  logic [3:0] byte_count;
  logic [7:0] active_command;
  logic [7:0] running_sum;
  logic [7:0] cell_count;
  logic [7:0] sensor_count;
  logic [4:0] frames_left;
  logic [5:0] element_number;

  logic        cells_bad;
  logic        sensors_bad;
  logic        armed;
  logic        frame_end;
  logic        sum_ok;
  logic        fire;
  logic        pend_go;
  logic [17:0] div3_prod;
  logic [15:0] div7_prod;
  logic [4:0]  cell_frames;
  logic [4:0]  temp_frames;
  logic [2:0]  elem_cnt;
  logic [5:0]  elem_next;
  logic [7:0]  limit;
  logic [63:0] frame_data;

  assign cells_bad   = (cell_count == 8'd0) || (cell_count >= 8'(MAX_CELLS));
  assign sensors_bad = (sensor_count == 8'd0) || (sensor_count >= 8'(MAX_SENSORS));
  assign armed       = frames_left != 5'd0;
  assign frame_end   = byte_count == 4'(FRAME_BYTES - 1);
  assign sum_ok      = running_sum == pend_byte;
  assign limit       = (active_command == CMD_CELL_MV) ? cell_count : sensor_count;

  // ceil of count / 3 and count / 7 by reciprocal multiply
  assign div3_prod   = 18'({1'b0, cell_count} + 9'd2) * 18'd171;
  assign div7_prod   = 16'({1'b0, sensor_count} + 9'd6) * 16'd37;
  assign cell_frames = div3_prod[13:9];
  assign temp_frames = div7_prod[12:8];

  always_comb begin
    fire = 1'b0;
    case (pend_action)
      ACT_START: begin
        fire = (((pend_command == CMD_CELL_MV) || (pend_command == CMD_BALANCE)) && cells_bad) ||
               ((pend_command == CMD_CELL_TEMP) && sensors_bad);
      end
      ACT_BYTE:    fire = armed && frame_end;
      ACT_TIMEOUT: fire = armed;
      default:     fire = 1'b0;
    endcase
  end

  assign pend_go     = pend_valid && (!fire || emit_free);
  assign items.ready = !pend_valid || pend_go;
  assign burst_load  = pend_go && fire;

  // elements taken by one cell-voltage or temperature frame
  always_comb begin
    logic [2:0] per_frame;
    per_frame = (active_command == CMD_CELL_MV) ? 3'(CELLS_PER_FRAME) : 3'(TEMPS_PER_FRAME);
    elem_cnt  = per_frame;
    for (int k = TEMPS_PER_FRAME - 1; k >= 0; k--) begin
      if ((3'(k) < per_frame) && hit_limit(element_number, 3'(k), limit)) begin
        elem_cnt = 3'(k + 1);
      end
    end
    elem_next = element_number + {3'b000, elem_cnt};
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      frame_data[8*j +: 8] = frame_store[4 + j];
    end
  end

  always_comb begin
    burst.data  = frame_data;
    burst.elem  = element_number;
    burst.limit = limit;
    burst.cmd   = active_command;
    burst.status = ST_OK;
    case (pend_action)
      ACT_START: begin
        burst.cmd    = pend_command;
        burst.status = ST_BAD_COUNT;
      end
      ACT_TIMEOUT: burst.status = ST_SHORT;
      ACT_BYTE: begin
        if (!sum_ok) begin
          burst.status = ST_CHECKSUM;
        end else if ((active_command == CMD_PACK) && (frame_store[8] == 8'd0) &&
                     (frame_store[9] == 8'd0)) begin
          burst.status = ST_INVALID;
        end
      end
      default: burst.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      pend_valid <= 1'b1;
    end else if (pend_go) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      pend_action  <= items.action;
      pend_command <= items.command;
      pend_byte    <= items.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go && (pend_action == ACT_BYTE) && armed) begin
      frame_store[byte_count] <= pend_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      active_command <= '0;
      running_sum    <= '0;
      cell_count     <= '0;
      sensor_count   <= '0;
      frames_left    <= '0;
      element_number <= '0;
    end else if (pend_go) begin
      case (pend_action)
        ACT_START: begin
          active_command <= pend_command;
          byte_count     <= '0;
          running_sum    <= '0;
          element_number <= '0;
          frames_left    <= '0;
          if ((pend_command >= CMD_PACK) && (pend_command <= CMD_STATUS)) begin
            frames_left <= 5'd1;
          end else if (pend_command == CMD_BALANCE) begin
            if (!cells_bad) frames_left <= 5'd1;
          end else if (pend_command == CMD_CELL_MV) begin
            if (!cells_bad) frames_left <= cell_frames;
          end else if (pend_command == CMD_CELL_TEMP) begin
            if (!sensors_bad) frames_left <= temp_frames;
          end
        end
        ACT_BYTE: begin
          if (armed) begin
            if (frame_end) begin
              byte_count  <= '0;
              running_sum <= '0;
              if (!sum_ok) begin
                frames_left <= '0;
              end else begin
                frames_left <= frames_left - 5'd1;
                if (active_command == CMD_STATUS) begin
                  cell_count   <= frame_store[4];
                  sensor_count <= frame_store[5];
                end
                if ((active_command == CMD_CELL_MV) || (active_command == CMD_CELL_TEMP)) begin
                  element_number <= elem_next;
                end
              end
            end else begin
              byte_count  <= byte_count + 4'd1;
              running_sum <= running_sum + pend_byte;
            end
          end
        end
        ACT_TIMEOUT: begin
          if (armed) begin
            frames_left <= '0;
            byte_count  <= '0;
            running_sum <= '0;
          end
        end
        default: begin
          byte_count <= byte_count;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/bmsrfd_emit.sv
`timescale 1ns / 1ps

module bmsrfd_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                burst_load,
  input  bmsrfd_pkg::burst_t  burst,
  output logic                emit_free,
  bmsrfd_out_if.source        results
);
  import bmsrfd_pkg::*;

  logic               busy;
  logic [2:0]         k;
  burst_t             cur;
  logic [4:0]         kind;
  logic [5:0]         index;
  logic signed [48:0] value;
  logic               cur_last;
  logic               pop;

  always_comb begin
    logic [7:0]  b [4:11];
    logic [15:0] hi;
    logic [15:0] lo;
    logic [9:0]  tsum;
    logic [9:0]  tround;
    logic [9:0]  thalf;
    logic [47:0] mask;
    logic [7:0]  tbyte;
    for (int j = 0; j < 8; j++) begin
      b[4 + j] = cur.data[8*j +: 8];
    end
    hi    = {b[4], b[5]};
    lo    = {b[7], b[8]};
    tsum  = 10'(b[4]) + 10'(b[6]) - 10'(2 * TEMP_OFFSET);
    tround = tsum + {9'd0, tsum[9]};
    thalf = tround >> 1;
    thalf[9] = tround[9];
    mask  = {b[9], b[8], b[7], b[6], b[5], b[4]};
    tbyte = cur.data[8*k +: 8];
    if (k == 3'd7) tbyte = 8'd0;
    kind     = K_PACK_V;
    index    = '0;
    value    = '0;
    cur_last = 1'b1;
    if (cur.status == ST_OK) begin
      case (cur.cmd)
        CMD_PACK: begin
          case (k)
            3'd0: begin kind = K_PACK_V; value = 49'(hi); cur_last = 1'b0; end
            3'd1: begin
              kind = K_PACK_I; value = 49'({b[8], b[9]}) - 49'(CURRENT_OFFSET);
              cur_last = 1'b0;
            end
            default: begin kind = K_SOC; value = 49'({b[10], b[11]}); end
          endcase
        end
        CMD_EXTREMES: begin
          case (k)
            3'd0: begin kind = K_MAX_MV; value = 49'(hi); cur_last = 1'b0; end
            3'd1: begin kind = K_MAX_CELL; value = 49'(b[6]); cur_last = 1'b0; end
            3'd2: begin kind = K_MIN_MV; value = 49'(lo); cur_last = 1'b0; end
            3'd3: begin kind = K_MIN_CELL; value = 49'(b[9]); cur_last = 1'b0; end
            default: begin kind = K_DELTA_MV; value = 49'(hi) - 49'(lo); end
          endcase
        end
        CMD_TEMP: begin
          kind  = K_AVG_TEMP;
          value = {{39{thalf[9]}}, thalf};
        end
        CMD_FET: begin
          case (k)
            3'd0: begin kind = K_CHG_STATE; value = 49'(b[4]); cur_last = 1'b0; end
            3'd1: begin kind = K_CHG_FET; value = 49'(b[5]); cur_last = 1'b0; end
            3'd2: begin kind = K_DSG_FET; value = 49'(b[6]); cur_last = 1'b0; end
            3'd3: begin kind = K_HEARTBEAT; value = 49'(b[7]); cur_last = 1'b0; end
            default: begin
              kind = K_RESIDUAL; value = 49'({b[8], b[9], b[10], b[11]});
            end
          endcase
        end
        CMD_STATUS: begin
          case (k)
            3'd0: begin kind = K_CELL_COUNT; value = 49'(b[4]); cur_last = 1'b0; end
            3'd1: begin kind = K_SENS_COUNT; value = 49'(b[5]); cur_last = 1'b0; end
            3'd2: begin kind = K_CHARGER; value = 49'(b[6]); cur_last = 1'b0; end
            3'd3: begin kind = K_LOAD; value = 49'(b[7]); cur_last = 1'b0; end
            3'd4: begin kind = K_DIO; value = 49'(b[8]); cur_last = 1'b0; end
            default: begin kind = K_CYCLES; value = 49'({b[9], b[10]}); end
          endcase
        end
        CMD_CELL_MV: begin
          kind     = K_CELL_MV;
          index    = cur.elem + {3'b000, k};
          cur_last = (k >= 3'(CELLS_PER_FRAME - 1)) || hit_limit(cur.elem, k, cur.limit);
          case (k)
            3'd0:    value = 49'({b[5], b[6]});
            3'd1:    value = 49'({b[7], b[8]});
            default: value = 49'({b[9], b[10]});
          endcase
        end
        CMD_CELL_TEMP: begin
          kind     = K_SENS_TEMP;
          index    = cur.elem + {3'b000, k};
          cur_last = (k >= 3'(TEMPS_PER_FRAME - 1)) || hit_limit(cur.elem, k, cur.limit);
          value    = 49'(cur.data[8*(k+1) +: 8]) - 49'(TEMP_OFFSET);
          if (k == 3'd7) value = 49'(tbyte);
        end
        default: begin
          if (k == 3'd0) begin
            kind = K_BAL_MASK; value = 49'(mask); cur_last = 1'b0;
          end else begin
            kind = K_BAL_ACTIVE; value = 49'(mask != 48'd0);
          end
        end
      endcase
    end
  end

  assign pop       = busy && results.ready;
  assign emit_free = !busy || (results.ready && cur_last);

  assign results.valid      = busy;
  assign results.status     = cur.status;
  assign results.cmd_echo   = cur.cmd;
  assign results.item_kind  = kind;
  assign results.item_index = index;
  assign results.item_value = value;
  assign results.last       = cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (burst_load) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (pop) begin
      if (cur_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      cur <= burst;
    end
  end

endmodule

FILE: verif/bms_response_frame_decoder_test.sv
`timescale 1ns / 1ps

module bms_response_frame_decoder_test;
  import bmsrfd_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 20;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  cmd;
    logic [4:0]  kind;
    logic [5:0]  idx;
    logic [48:0] value;
    logic        last;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]    store [FRAME_BYTES];
    int            nbytes = 0;
    logic [7:0]    cmd_now = '0;
    logic [7:0]    checksum_acc = '0;
    logic [7:0]    n_cells = '0;
    logic [7:0]    n_sensors = '0;
    logic [4:0]    frames_to_go = '0;
    logic [5:0]    elem = '0;
    frame_result_t awaited [$];
    int            mismatches = 0;

    function int pending();
      return awaited.size();
    endfunction

    function void push(logic [2:0] st, logic [4:0] kind, logic [5:0] idx, longint val);
      frame_result_t r;
      r.status = st;
      r.cmd = cmd_now;
      r.kind = kind;
      r.idx = idx;
      r.value = val[48:0];
      r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    function longint word_at(int at);
      longint w;
      w = {store[at], store[at + 1]};
      return w;
    endfunction

    function void decode_frame();
      longint hi;
      longint lo;
      longint wide;
      int t;
      logic [47:0] mask;
      case (cmd_now)
        CMD_PACK: begin
          if (word_at(8) == 0) begin
            push(ST_INVALID, '0, '0, 0);
          end else begin
            push(ST_OK, K_PACK_V, '0, word_at(4));
            push(ST_OK, K_PACK_I, '0, word_at(8) - CURRENT_OFFSET);
            push(ST_OK, K_SOC, '0, word_at(10));
          end
        end
        CMD_EXTREMES: begin
          hi = word_at(4);
          lo = word_at(7);
          push(ST_OK, K_MAX_MV, '0, hi);
          push(ST_OK, K_MAX_CELL, '0, longint'(store[6]));
          push(ST_OK, K_MIN_MV, '0, lo);
          push(ST_OK, K_MIN_CELL, '0, longint'(store[9]));
          push(ST_OK, K_DELTA_MV, '0, hi - lo);
        end
        CMD_TEMP: begin
          t = int'(store[4]) + int'(store[6]) - 2 * TEMP_OFFSET;
          push(ST_OK, K_AVG_TEMP, '0, longint'(t / 2));
        end
        CMD_FET: begin
          wide = {store[8], store[9], store[10], store[11]};
          push(ST_OK, K_CHG_STATE, '0, longint'(store[4]));
          push(ST_OK, K_CHG_FET, '0, longint'(store[5]));
          push(ST_OK, K_DSG_FET, '0, longint'(store[6]));
          push(ST_OK, K_HEARTBEAT, '0, longint'(store[7]));
          push(ST_OK, K_RESIDUAL, '0, wide);
        end
        CMD_STATUS: begin
          n_cells = store[4];
          n_sensors = store[5];
          push(ST_OK, K_CELL_COUNT, '0, longint'(store[4]));
          push(ST_OK, K_SENS_COUNT, '0, longint'(store[5]));
          push(ST_OK, K_CHARGER, '0, longint'(store[6]));
          push(ST_OK, K_LOAD, '0, longint'(store[7]));
          push(ST_OK, K_DIO, '0, longint'(store[8]));
          push(ST_OK, K_CYCLES, '0, word_at(9));
        end
        CMD_CELL_MV: begin
          for (int i = 0; i < CELLS_PER_FRAME; i++) begin
            push(ST_OK, K_CELL_MV, elem, word_at(5 + 2 * i));
            elem = elem + 6'd1;
            if ({2'b00, elem} >= n_cells) break;
          end
        end
        CMD_CELL_TEMP: begin
          for (int i = 0; i < TEMPS_PER_FRAME; i++) begin
            push(ST_OK, K_SENS_TEMP, elem, longint'(int'(store[5 + i]) - TEMP_OFFSET));
            elem = elem + 6'd1;
            if ({2'b00, elem} >= n_sensors) break;
          end
        end
        default: begin
          mask = {store[9], store[8], store[7], store[6], store[5], store[4]};
          wide = mask;
          push(ST_OK, K_BAL_MASK, '0, wide);
          push(ST_OK, K_BAL_ACTIVE, '0, (mask != '0) ? 1 : 0);
        end
      endcase
    endfunction

    function void note_item(logic [1:0] action, logic [7:0] command, logic [7:0] rx_byte);
      int before_count;
      before_count = awaited.size();
      case (action)
        ACT_START: begin
          cmd_now = command;
          nbytes = 0;
          checksum_acc = '0;
          elem = '0;
          frames_to_go = '0;
          if (command >= CMD_PACK && command <= CMD_STATUS) begin
            frames_to_go = 5'd1;
          end else if (command == CMD_CELL_MV || command == CMD_BALANCE) begin
            if (n_cells < 1 || n_cells >= MAX_CELLS) push(ST_BAD_COUNT, '0, '0, 0);
            else if (command == CMD_BALANCE) frames_to_go = 5'd1;
            else frames_to_go = 5'((int'(n_cells) + 2) / CELLS_PER_FRAME);
          end else if (command == CMD_CELL_TEMP) begin
            if (n_sensors < 1 || n_sensors >= MAX_SENSORS) push(ST_BAD_COUNT, '0, '0, 0);
            else frames_to_go = 5'((int'(n_sensors) + 6) / TEMPS_PER_FRAME);
          end
        end
        ACT_BYTE: begin
          if (frames_to_go != 0) begin
            if (nbytes < FRAME_BYTES - 1) checksum_acc = checksum_acc + rx_byte;
            store[nbytes] = rx_byte;
            nbytes++;
            if (nbytes >= FRAME_BYTES) begin
              nbytes = 0;
              if (checksum_acc != store[FRAME_BYTES - 1]) begin
                push(ST_CHECKSUM, '0, '0, 0);
                frames_to_go = '0;
              end else begin
                decode_frame();
                frames_to_go = frames_to_go - 5'd1;
              end
              checksum_acc = '0;
            end
          end
        end
        ACT_TIMEOUT: begin
          if (frames_to_go != 0) begin
            push(ST_SHORT, '0, '0, 0);
            frames_to_go = '0;
            nbytes = 0;
            checksum_acc = '0;
          end
        end
        default: ;
      endcase
      if (awaited.size() > before_count) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void show(string tag, frame_result_t r);
      $display("%s status %0d cmd %02h kind %0d index %0d value %0d last %0b", tag,
               r.status, r.cmd, r.kind, r.idx, $signed(r.value), r.last);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) show("unexpected result:", got);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.cmd !== want.cmd || got.kind !== want.kind ||
          got.idx !== want.idx || got.value !== want.value || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          show("result mismatch, expected:", want);
          show("                 actual:  ", got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bmsrfd_in_if item_bus ();
  bmsrfd_out_if result_bus ();

  bms_response_frame_decoder DUT (
    .clk(clk),
    .rst(rst),
    .items(item_bus),
    .results(result_bus)
  );

  frame_scoreboard sb = new;
  logic [7:0] frame_buf [FRAME_BYTES];
  frame_result_t seen;
  int sent_items = 0;
  int cycles = 0;
  int tx_odds = 2;
  int rx_odds = 2;
  int holds_wanted = 0;
  int holds_done = 0;
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    forever begin
      if (holds_wanted != holds_done) begin
        holds_done++;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady && rx_odds != 0 && $urandom_range(1, 8) <= rx_odds) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      seen.status = result_bus.status;
      seen.cmd = result_bus.cmd_echo;
      seen.kind = result_bus.item_kind;
      seen.idx = result_bus.item_index;
      seen.value = result_bus.item_value;
      seen.last = result_bus.last;
      sb.check_result(seen);
    end
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return rand8();
    endcase
  endfunction

  function automatic logic [7:0] pick_cells();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'(MAX_CELLS - 1);
      3: return 8'(MAX_CELLS);
      4: return 8'($urandom_range(MAX_CELLS + 1, 255));
      default: return 8'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_sensors();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'(MAX_SENSORS - 1);
      3: return 8'(MAX_SENSORS);
      4: return 8'($urandom_range(MAX_SENSORS + 1, 255));
      default: return 8'($urandom_range(2, MAX_SENSORS - 2));
    endcase
  endfunction

  function automatic void seal_frame();
    logic [7:0] total;
    total = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) total = total + frame_buf[i];
    frame_buf[FRAME_BYTES - 1] = total;
  endfunction

  function automatic void fill_frame(logic [7:0] cmd, logic [7:0] cells, logic [7:0] sensors);
    for (int i = 0; i < FRAME_BYTES - 1; i++) frame_buf[i] = rand_byte();
    if (cmd == CMD_PACK && $urandom_range(0, 3) == 0) begin
      frame_buf[8] = '0;
      frame_buf[9] = '0;
    end
    if (cmd == CMD_BALANCE && $urandom_range(0, 3) == 0) begin
      for (int i = 4; i < 10; i++) frame_buf[i] = '0;
    end
    if (cmd == CMD_STATUS) begin
      frame_buf[4] = cells;
      frame_buf[5] = sensors;
    end
    seal_frame();
  endfunction

  task automatic put_item(input logic [1:0] act, input logic [7:0] cmd, input logic [7:0] data);
    if (!steady && tx_odds != 0 && $urandom_range(1, 8) <= tx_odds) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.action <= act;
    item_bus.command <= cmd;
    item_bus.rx_byte <= data;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(act, cmd, data);
    sent_items++;
  endtask

  task automatic send_bytes(input int cut, input bit corrupt);
    logic [7:0] b;
    for (int i = 0; i < cut; i++) begin
      b = frame_buf[i];
      if (i == FRAME_BYTES - 1 && corrupt) b = b ^ 8'($urandom_range(1, 255));
      put_item(ACT_BYTE, rand8(), b);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // start, then whole frames until the response is complete; broken frames when not clean
  task automatic run_session(input logic [7:0] cmd, input bit clean,
                             input logic [7:0] cells, input logic [7:0] sensors);
    int pick;
    tx_odds = $urandom_range(0, 3);
    rx_odds = $urandom_range(0, 3);
    put_item(ACT_START, cmd, rand8());
    while (sb.frames_to_go != 0) begin
      fill_frame(cmd, cells, sensors);
      pick = clean ? 99 : $urandom_range(0, 24);
      if (pick == 0) begin
        send_bytes($urandom_range(0, FRAME_BYTES - 1), 1'b0);
        put_item(ACT_TIMEOUT, rand8(), rand8());
      end else if (pick == 1) begin
        send_bytes(FRAME_BYTES, 1'b1);
      end else if (pick == 2) begin
        // abandoned mid-frame, the next start discards it
        send_bytes($urandom_range(1, FRAME_BYTES - 1), 1'b0);
        return;
      end else begin
        send_bytes(FRAME_BYTES, 1'b0);
      end
    end
  endtask

  task automatic send_noise();
    int count;
    count = $urandom_range(1, 4);
    repeat (count) put_item(2'($urandom_range(0, 3)), rand8(), rand8());
    sent_items -= count;
  endtask

  initial begin
    int base;
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.action <= ACT_BYTE;
    item_bus.command <= '0;
    item_bus.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored items, unknown commands, bad counts, short frames, restart
    put_item(ACT_RESERVED, 8'hFF, 8'hFF);
    put_item(ACT_BYTE, 8'h00, 8'hFF);
    put_item(ACT_TIMEOUT, 8'hFF, 8'h00);
    put_item(ACT_START, 8'h00, 8'h00);
    put_item(ACT_START, 8'hFF, 8'hFF);
    put_item(ACT_START, CMD_PACK - 8'd1, 8'h00);
    put_item(ACT_START, CMD_BALANCE + 8'd1, 8'h00);
    put_item(ACT_BYTE, 8'h00, 8'h55);
    put_item(ACT_START, CMD_CELL_MV, 8'h00);
    put_item(ACT_START, CMD_CELL_TEMP, 8'h00);
    put_item(ACT_START, CMD_BALANCE, 8'h00);
    put_item(ACT_START, CMD_PACK, 8'h00);
    put_item(ACT_TIMEOUT, 8'h00, 8'h00);
    put_item(ACT_START, CMD_EXTREMES, 8'h00);
    fill_frame(CMD_EXTREMES, '0, '0);
    send_bytes(5, 1'b0);
    put_item(ACT_START, CMD_TEMP, 8'h00);
    put_item(ACT_TIMEOUT, 8'h00, 8'h00);
    // zero current
    put_item(ACT_START, CMD_PACK, 8'h00);
    fill_frame(CMD_PACK, '0, '0);
    frame_buf[8] = '0;
    frame_buf[9] = '0;
    seal_frame();
    send_bytes(FRAME_BYTES, 1'b0);

    // random sequences
    base = sent_items;
    while (sent_items < base + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1, 2: run_session(CMD_STATUS, 1'b0, pick_cells(), pick_sensors());
        default: run_session(CMD_PACK + 8'($urandom_range(0, 7)), 1'b0,
                             pick_cells(), pick_sensors());
      endcase
    end

    // fill the block while results are held off, then let it drain
    run_session(CMD_STATUS, 1'b1, 8'd6, 8'(MAX_SENSORS - 1));
    holds_wanted++;
    run_session(CMD_CELL_MV, 1'b1, '0, '0);
    drain();

    // back to back, largest sensor count
    steady = 1'b1;
    run_session(CMD_CELL_TEMP, 1'b1, '0, '0);
    item_bus.valid <= 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bmsrfd_pkg.sv
hw/rtl/bmsrfd_in_if.sv
hw/rtl/bmsrfd_out_if.sv
hw/rtl/bmsrfd_rx.sv
hw/rtl/bmsrfd_emit.sv
hw/rtl/bms_response_frame_decoder.sv
verif/bms_response_frame_decoder_test.sv
